/* hdl/jpa1_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants for the jpeg app1 marker scanner
// no dependencies

package jpa1_pkg;

    localparam int OFFSET_BITS_DEF = 32;
    localparam int FLEN_W          = 32;
    localparam int POFF_W          = 32;
    localparam int PLEN_W          = 16;
    localparam int STAT_W          = 3;

    localparam logic [7:0] BYTE_FF   = 8'hFF;
    localparam logic [7:0] BYTE_SOI  = 8'hD8;
    localparam logic [7:0] BYTE_SOS  = 8'hDA;
    localparam logic [7:0] BYTE_APP1 = 8'hE1;

    localparam logic [STAT_W-1:0] ST_APP1_FOUND = 3'd0;
    localparam logic [STAT_W-1:0] ST_NO_SOI     = 3'd1;
    localparam logic [STAT_W-1:0] ST_BAD_MARKER = 3'd2;
    localparam logic [STAT_W-1:0] ST_SOS        = 3'd3;
    localparam logic [STAT_W-1:0] ST_TRUNCATED  = 3'd4;
    localparam logic [STAT_W-1:0] ST_END_DATA   = 3'd5;
    localparam logic [STAT_W-1:0] ST_BAD_LENGTH = 3'd6;

    typedef struct packed {
        logic              valid;
        logic [STAT_W-1:0] status;
        logic [POFF_W-1:0] offset;
        logic [PLEN_W-1:0] length;
    } t_result;

endpackage

/* hdl/jpa1_scan.sv */
`timescale 1ns / 1ps
// marker walk state and per-beat decision logic
// depends on jpa1_pkg

module jpa1_scan #(
    parameter int OFFSET_BITS = jpa1_pkg::OFFSET_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_step,
    input  logic [7:0]                   i_byte,
    input  logic                         i_last,
    input  logic [jpa1_pkg::FLEN_W-1:0]  i_file_length,
    output jpa1_pkg::t_result            o_result
);
    import jpa1_pkg::*;

    localparam int CW = ((OFFSET_BITS > FLEN_W) ? OFFSET_BITS : FLEN_W) + 18;

    typedef enum logic [2:0] {
        PH_START0, PH_START1, PH_MARK, PH_CODE, PH_LENHI, PH_LENLO, PH_SKIP
    } t_phase;

    t_phase                 r_phase, n_phase;
    logic [OFFSET_BITS-1:0] r_pos, n_pos;
    logic [7:0]             r_marker, n_marker;
    logic [7:0]             r_len_hi, n_len_hi;
    logic [PLEN_W-1:0]      r_skip, n_skip;
    logic                   r_done, n_done;

    logic [FLEN_W-1:0] lim;
    logic [CW-1:0]     p_x, lim_x, len_x, target_x;
    logic [PLEN_W-1:0] len16, skip_dec;
    t_result           res;

    assign lim      = (i_file_length >= FLEN_W'(2)) ? i_file_length - FLEN_W'(2) : '0;
    assign p_x      = CW'(r_pos);
    assign lim_x    = CW'(lim);
    assign len16    = {r_len_hi, i_byte};
    assign len_x    = CW'(len16);
    assign target_x = p_x - CW'(1) + len_x;
    assign skip_dec = (r_skip != '0) ? r_skip - PLEN_W'(1) : r_skip;

    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_marker = r_marker;
        n_len_hi = r_len_hi;
        n_skip   = r_skip;
        n_done   = r_done;
        res      = '0;
        if (!r_done) begin
            case (r_phase)
                PH_START0: begin
                    if (i_file_length < FLEN_W'(2) || i_byte != BYTE_FF) begin
                        res.valid  = 1'b1;
                        res.status = ST_NO_SOI;
                    end else begin
                        n_phase = PH_START1;
                    end
                end
                PH_START1: begin
                    res.valid = 1'b1;
                    if (i_byte != BYTE_SOI) begin
                        res.status = ST_NO_SOI;
                    end else if (!(lim > FLEN_W'(2))) begin
                        res.status = ST_END_DATA;
                    end else begin
                        res.valid = 1'b0;
                        n_phase   = PH_MARK;
                    end
                end
                PH_MARK: begin
                    if (i_byte != BYTE_FF) begin
                        res.valid  = 1'b1;
                        res.status = ST_BAD_MARKER;
                    end else begin
                        n_phase = PH_CODE;
                    end
                end
                PH_CODE: begin
                    res.valid = 1'b1;
                    if (i_byte == BYTE_FF) begin
                        // fill byte before the marker code
                        res.status = ST_END_DATA;
                        if (p_x < lim_x) begin
                            res.valid = 1'b0;
                        end
                    end else if (i_byte == BYTE_SOS) begin
                        res.status = ST_SOS;
                    end else if (p_x + CW'(3) >= lim_x) begin
                        res.status = ST_TRUNCATED;
                    end else begin
                        res.valid = 1'b0;
                        n_marker  = i_byte;
                        n_phase   = PH_LENHI;
                    end
                end
                PH_LENHI: begin
                    n_len_hi = i_byte;
                    n_phase  = PH_LENLO;
                end
                PH_LENLO: begin
                    res.valid = 1'b1;
                    if (r_marker == BYTE_APP1 && len16 < PLEN_W'(2)) begin
                        res.status = ST_BAD_LENGTH;
                    end else if (r_marker == BYTE_APP1 && target_x <= lim_x) begin
                        res.status = ST_APP1_FOUND;
                        res.offset = POFF_W'(p_x + CW'(1));
                        res.length = len16 - PLEN_W'(2);
                    end else if (len16 < PLEN_W'(2)) begin
                        res.status = ST_BAD_MARKER;
                    end else if (!(target_x < lim_x)) begin
                        res.status = ST_END_DATA;
                    end else begin
                        res.valid = 1'b0;
                        n_skip    = len16 - PLEN_W'(2);
                        n_phase   = (len16 != PLEN_W'(2)) ? PH_SKIP : PH_MARK;
                    end
                end
                PH_SKIP: begin
                    n_skip = skip_dec;
                    if (skip_dec == '0) begin
                        n_phase = PH_MARK;
                    end
                end
                default: begin
                    n_phase = PH_START0;
                end
            endcase
            if (res.valid) begin
                n_done = 1'b1;
            end
            if (r_pos != '1) begin
                n_pos = r_pos + OFFSET_BITS'(1);
            end
        end
        if (i_last) begin
            if (!r_done && !res.valid) begin
                res.valid  = 1'b1;
                res.status = ST_TRUNCATED;
            end
            n_phase  = PH_START0;
            n_pos    = '0;
            n_marker = '0;
            n_len_hi = '0;
            n_skip   = '0;
            n_done   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_START0;
            r_pos    <= '0;
            r_marker <= '0;
            r_len_hi <= '0;
            r_skip   <= '0;
            r_done   <= 1'b0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_marker <= n_marker;
            r_len_hi <= n_len_hi;
            r_skip   <= n_skip;
            r_done   <= n_done;
        end
    end

    assign o_result = res;

endmodule

/* hdl/jpeg_app1_marker_scanner.sv */
`timescale 1ns / 1ps
// jpeg app1 marker scanner, top level
// depends on jpa1_pkg and jpa1_scan
//
// usage:
//   write the file's byte count on i_cfg_wr_data with i_cfg_wr_en before the file
//   stream the file one byte per beat on the slave side, i_s_tlast on the final byte
//   at most one result beat per file on the master side: status in tuser,
//   payload offset and length in tdata (zero unless status is app1 found)
//   bytes after the decision are consumed and dropped until tlast
// timing:
//   one byte per cycle sustained unless a result waits on i_m_tready; a beat is held in the input register,
//   then the walk logic decides and the result register is loaded
// reset:
//   i_rst_n low clears the walk state, file length and the valid flags of both registers
// stalls:
//   while a result waits on i_m_tready the input register still takes a beat;
//   further bytes stall only once that beat needs to move on

module jpeg_app1_marker_scanner #(
    parameter int OFFSET_BITS = jpa1_pkg::OFFSET_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [jpa1_pkg::FLEN_W-1:0]   i_cfg_wr_data,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [7:0]                    i_s_tdata,   // data_byte
    input  logic                          i_s_tlast,   // last_byte
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [47:0]                   o_m_tdata,   // payload_offset, payload_length
    output logic [jpa1_pkg::STAT_W-1:0]   o_m_tuser    // status
);
    import jpa1_pkg::*;

    logic [FLEN_W-1:0] r_file_length;
    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_in_last;
    logic              r_out_valid;
    logic [STAT_W-1:0] r_out_status;
    logic [POFF_W-1:0] r_out_offset;
    logic [PLEN_W-1:0] r_out_length;

    logic    can_proc;
    logic    step;
    t_result result;

    assign can_proc   = !r_out_valid || i_m_tready;
    assign step       = r_in_valid && can_proc;
    assign o_s_tready = !r_in_valid || can_proc;

    jpa1_scan #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_byte        (r_in_byte),
        .i_last        (r_in_last),
        .i_file_length (r_file_length),
        .o_result      (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_file_length <= '0;
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_file_length <= i_cfg_wr_data;
            end
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (can_proc) begin
                r_out_valid <= step && result.valid;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
        if (step && result.valid) begin
            r_out_status <= result.status;
            r_out_offset <= result.offset;
            r_out_length <= result.length;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_length, r_out_offset};
    assign o_m_tuser  = r_out_status;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// self-checking bench for jpeg_app1_marker_scanner: directed and random jpeg-like byte streams
// checked against a built-in model of the marker walk; depends on jpa1_pkg and jpeg_app1_marker_scanner

module tb_top;
    import jpa1_pkg::*;

    typedef enum logic [2:0] {
        WALK_SOI0, WALK_SOI1, WALK_MARK, WALK_CODE, WALK_LEN_HI, WALK_LEN_LO, WALK_SKIP
    } t_walk_phase;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_wr_en   = 1'b0;
    logic [FLEN_W-1:0] i_cfg_wr_data = '0;
    logic              i_s_tvalid    = 1'b0;
    logic              o_s_tready;
    logic [7:0]        i_s_tdata     = '0;
    logic              i_s_tlast     = 1'b0;
    logic              o_m_tvalid;
    logic              i_m_tready    = 1'b0;
    logic [47:0]       o_m_tdata;
    logic [STAT_W-1:0] o_m_tuser;

    jpeg_app1_marker_scanner u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tlast     (i_s_tlast),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .o_m_tuser     (o_m_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // walk state of the model
    logic [FLEN_W-1:0] file_len   = '0;
    t_walk_phase       walk_ph    = WALK_SOI0;
    logic [31:0]       byte_pos   = '0;
    logic [7:0]        seg_marker = '0;
    logic [7:0]        len_hi     = '0;
    logic [15:0]       skip_left  = '0;
    logic              decided    = 1'b0;

    logic [8:0]  file_bytes_q[$];   // {last, byte}
    t_result     pending_reports[$];
    logic [7:0]  file_buf[$];
    int          sent_bytes   = 0;
    int          errors       = 0;
    bit          gaps_on      = 1'b0;
    int          send_gap     = 0;
    int          recv_stall   = 0;
    logic [8:0]  beat;
    t_result     exp_r;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    function automatic bit walk_byte(input logic [7:0] b, output t_result r);
        longint unsigned p, lim, seg_len, seg_start;
        p = {32'd0, byte_pos};
        lim = {32'd0, file_len};
        lim = (lim >= 2) ? lim - 2 : 0;
        r = '0;
        r.valid = 1'b1;
        case (walk_ph)
            WALK_SOI0: begin
                if (file_len < 2 || b != BYTE_FF) begin
                    r.status = ST_NO_SOI;
                    return 1'b1;
                end
                walk_ph = WALK_SOI1;
            end
            WALK_SOI1: begin
                if (b != BYTE_SOI) begin
                    r.status = ST_NO_SOI;
                    return 1'b1;
                end
                if (!(lim > 2)) begin
                    r.status = ST_END_DATA;
                    return 1'b1;
                end
                walk_ph = WALK_MARK;
            end
            WALK_MARK: begin
                if (b != BYTE_FF) begin
                    r.status = ST_BAD_MARKER;
                    return 1'b1;
                end
                walk_ph = WALK_CODE;
            end
            WALK_CODE: begin
                if (b == BYTE_FF) begin
                    if (!(p < lim)) begin
                        r.status = ST_END_DATA;
                        return 1'b1;
                    end
                end else if (b == BYTE_SOS) begin
                    r.status = ST_SOS;
                    return 1'b1;
                end else if (p + 3 >= lim) begin
                    r.status = ST_TRUNCATED;
                    return 1'b1;
                end else begin
                    seg_marker = b;
                    walk_ph = WALK_LEN_HI;
                end
            end
            WALK_LEN_HI: begin
                len_hi = b;
                walk_ph = WALK_LEN_LO;
            end
            WALK_LEN_LO: begin
                seg_len = {48'd0, len_hi, b};
                seg_start = p - 1;
                if (seg_marker == BYTE_APP1) begin
                    if (seg_len < 2) begin
                        r.status = ST_BAD_LENGTH;
                        return 1'b1;
                    end
                    if (seg_start + seg_len <= lim) begin
                        r.status = ST_APP1_FOUND;
                        r.offset = POFF_W'(p + 1);
                        r.length = PLEN_W'(seg_len - 2);
                        return 1'b1;
                    end
                end
                if (seg_len < 2) begin
                    r.status = ST_BAD_MARKER;
                    return 1'b1;
                end
                if (!(seg_start + seg_len < lim)) begin
                    r.status = ST_END_DATA;
                    return 1'b1;
                end
                skip_left = 16'(seg_len - 2);
                walk_ph = (skip_left != 0) ? WALK_SKIP : WALK_MARK;
            end
            default: begin
                if (skip_left != 0) skip_left = skip_left - 1'b1;
                if (skip_left == 0) walk_ph = WALK_MARK;
            end
        endcase
        return 1'b0;
    endfunction

    function automatic void take_byte(input logic [7:0] b, input logic last);
        t_result r;
        bit      hit;
        bit      was_decided;
        was_decided = decided;
        hit = 1'b0;
        r = '0;
        if (!was_decided) begin
            hit = walk_byte(b, r);
            if (hit) decided = 1'b1;
            if (byte_pos != '1) byte_pos = byte_pos + 1'b1;
        end
        if (last) begin
            if (!was_decided && !hit) begin
                r = '0;
                r.valid = 1'b1;
                r.status = ST_TRUNCATED;
                hit = 1'b1;
            end
            walk_ph = WALK_SOI0;
            byte_pos = '0;
            seg_marker = '0;
            len_hi = '0;
            skip_left = '0;
            decided = 1'b0;
        end
        if (hit) pending_reports.push_back(r);
    endfunction

    // slave side driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) take_byte(i_s_tdata, i_s_tlast);
            if (!i_s_tvalid || o_s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_s_tvalid <= 1'b0;
                end else if (file_bytes_q.size() != 0) begin
                    beat = file_bytes_q.pop_front();
                    i_s_tdata <= beat[7:0];
                    i_s_tlast <= beat[8];
                    i_s_tvalid <= 1'b1;
                    send_gap = (gaps_on && $urandom_range(0, 2) == 0) ? gap_len() : 0;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // master side monitor and checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (pending_reports.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, actual status %0d data %h",
                             $time, o_m_tuser, o_m_tdata);
                    errors++;
                end else begin
                    exp_r = pending_reports.pop_front();
                    if (o_m_tuser !== exp_r.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, exp_r.status, o_m_tuser);
                        errors++;
                    end
                    if (o_m_tdata[31:0] !== exp_r.offset) begin
                        $display("%0t: payload offset expected %0d actual %0d",
                                 $time, exp_r.offset, o_m_tdata[31:0]);
                        errors++;
                    end
                    if (o_m_tdata[47:32] !== exp_r.length) begin
                        $display("%0t: payload length expected %0d actual %0d",
                                 $time, exp_r.length, o_m_tdata[47:32]);
                        errors++;
                    end
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
                if (gaps_on && $urandom_range(0, 3) == 0) recv_stall = gap_len();
            end
        end
    end

    task automatic settle();
        @(negedge i_clk);
        while (file_bytes_q.size() != 0 || i_s_tvalid || pending_reports.size() != 0)
            @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic start_phase(input logic [FLEN_W-1:0] v);
        settle();
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        file_len = v;
    endtask

    function automatic void queue_file();
        for (int k = 0; k < file_buf.size(); k++)
            file_bytes_q.push_back({k == file_buf.size() - 1, file_buf[k]});
        sent_bytes += file_buf.size();
    endfunction

    function automatic int body_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return $urandom_range(0, 12);
        if (r < 98) return $urandom_range(13, 60);
        return $urandom_range(200, 400);
    endfunction

    function automatic void build_file();
        int         nseg;
        int         blen;
        int         ending;
        int         noise;
        int         cut;
        logic [7:0] code;
        logic [15:0] seg_len;
        file_buf.delete();
        file_buf.push_back(BYTE_FF);
        file_buf.push_back(BYTE_SOI);
        nseg = $urandom_range(0, 4);
        for (int s = 0; s < nseg; s++) begin
            // fill bytes ahead of the marker code
            repeat (($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0)
                file_buf.push_back(BYTE_FF);
            file_buf.push_back(BYTE_FF);
            case ($urandom_range(0, 7))
                0: code = BYTE_APP1;
                1: code = 8'hE0;
                2: code = 8'hDB;
                3: code = 8'hC4;
                4: code = 8'hC0;
                5: code = 8'hFE;
                6: code = 8'hE2;
                default: code = 8'($urandom);
            endcase
            file_buf.push_back(code);
            if ($urandom_range(0, 19) == 0) begin
                // length too small to cover its own field
                seg_len = 16'($urandom_range(0, 1));
                blen = 0;
            end else begin
                blen = body_len();
                seg_len = 16'(blen + 2);
            end
            file_buf.push_back(seg_len[15:8]);
            file_buf.push_back(seg_len[7:0]);
            repeat (blen) file_buf.push_back(8'($urandom));
        end
        ending = $urandom_range(0, 9);
        if (ending < 4) begin
            file_buf.push_back(BYTE_FF);
            file_buf.push_back(BYTE_SOS);
            repeat ($urandom_range(2, 6)) file_buf.push_back(8'($urandom));
        end else if (ending < 7) begin
            blen = $urandom_range(0, 8);
            seg_len = 16'(blen + 2);
            file_buf.push_back(BYTE_FF);
            file_buf.push_back(BYTE_APP1);
            file_buf.push_back(seg_len[15:8]);
            file_buf.push_back(seg_len[7:0]);
            repeat (blen) file_buf.push_back(8'($urandom));
        end
        file_buf.push_back(BYTE_FF);
        file_buf.push_back(8'hD9);
        noise = $urandom_range(0, 9);
        if (noise == 0) begin
            file_buf[$urandom_range(0, file_buf.size() - 1)] = 8'($urandom);
        end else if (noise == 1) begin
            cut = $urandom_range(1, file_buf.size());
            while (file_buf.size() > cut) void'(file_buf.pop_back());
        end
    endfunction

    initial begin
        int unsigned sz;
        int unsigned d;
        logic [FLEN_W-1:0] flen_pick;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // short file, start code at the limit, empty segment body
        start_phase('0);
        file_buf = '{BYTE_FF};
        queue_file();
        start_phase(32'd4);
        file_buf = '{BYTE_FF, BYTE_SOI};
        queue_file();
        start_phase(32'd9);
        file_buf = '{BYTE_FF, BYTE_SOI, BYTE_FF, 8'hE0, 8'h00, 8'h02, BYTE_FF, BYTE_SOS};
        queue_file();
        // fill byte then largest app1 length
        start_phase('1);
        file_buf = '{BYTE_FF, BYTE_SOI, BYTE_FF, BYTE_FF, BYTE_APP1, 8'hFF, 8'hFF};
        queue_file();
        // tiny app1 length, bad marker start, early end
        gaps_on = 1'b1;
        start_phase(32'd100);
        file_buf = '{BYTE_FF, BYTE_SOI, BYTE_FF, BYTE_APP1, 8'h00, 8'h01};
        queue_file();
        file_buf = '{BYTE_FF, BYTE_SOI, 8'h00};
        queue_file();
        file_buf = '{BYTE_FF};
        queue_file();

        while (sent_bytes < 1050) begin
            build_file();
            sz = file_buf.size();
            case ($urandom_range(0, 9))
                6: begin
                    d = $urandom_range(1, 6);
                    flen_pick = (sz > d) ? sz - d : 0;
                end
                7: flen_pick = sz + $urandom_range(1, 40);
                8: flen_pick = $urandom;
                9: flen_pick = $urandom_range(0, 8);
                default: flen_pick = sz;
            endcase
            start_phase(flen_pick);
            gaps_on = ($urandom_range(0, 4) != 0);
            queue_file();
            repeat (($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0) begin
                build_file();
                queue_file();
            end
        end

        settle();
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #15_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

/* sim.f */
hdl/jpa1_pkg.sv
hdl/jpa1_scan.sv
hdl/jpeg_app1_marker_scanner.sv
tb/tb_top.sv
